// ===== hdl/wpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wpsd_pkg
// Shared types and constants of the WAV PCM stream parser.
// ----------------------------------------------------------------------------
package wpsd_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_SIZE_BASIC = 32'd16;
  localparam logic [31:0] FMT_SIZE_EXT   = 32'd18;
  localparam logic [31:0] FMT_SIZE_WIDE  = 32'd40;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_RIFF  = 3'd1;
  localparam logic [2:0] ERR_WAVE  = 3'd2;
  localparam logic [2:0] ERR_FSIZE = 3'd3;
  localparam logic [2:0] ERR_PCM   = 3'd4;
  localparam logic [2:0] ERR_CHAN  = 3'd5;
  localparam logic [2:0] ERR_RATE  = 3'd6;
  localparam logic [2:0] ERR_BITS  = 3'd7;

  localparam int unsigned TDATA_W = 112;

  typedef struct packed {
    logic       file_start;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         error_code;
    logic [31:0]        data_length;
    logic [4:0]         sample_bits;
    logic [1:0]         channel_count;
    logic [31:0]        sample_rate;
    logic signed [15:0] right_sample;
    logic signed [15:0] left_sample;
    logic [1:0]         result_kind;
  } result_t;

endpackage

// ===== hdl/wpsd_in_stage.sv =====
// ----------------------------------------------------------------------------
// wpsd_in_stage
// Input register of the byte stream.
// ----------------------------------------------------------------------------
module wpsd_in_stage
  import wpsd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  in_item_t req_item_i,
  input  logic     advance_i,
  output logic     item_valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  assign req_ready_o  = !valid_q || advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_ready_o) begin
      valid_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_ready_o && req_valid_i) begin
      item_q <= req_item_i;
    end
  end

endmodule

// ===== hdl/wpsd_parser.sv =====
// ----------------------------------------------------------------------------
// wpsd_parser
// Header and sample parser state with its one-byte step logic.
// ----------------------------------------------------------------------------
module wpsd_parser
  import wpsd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     item_en_i,
  input  in_item_t item_i,
  output logic     res_valid_o,
  output result_t  res_o
);

  localparam logic [3:0] PH_RIFF   = 4'd0;
  localparam logic [3:0] PH_RSIZE  = 4'd1;
  localparam logic [3:0] PH_WAVE   = 4'd2;
  localparam logic [3:0] PH_HUNT   = 4'd3;
  localparam logic [3:0] PH_FSIZE  = 4'd4;
  localparam logic [3:0] PH_TAGCH  = 4'd5;
  localparam logic [3:0] PH_RATE   = 4'd6;
  localparam logic [3:0] PH_BRATE  = 4'd7;
  localparam logic [3:0] PH_ALBITS = 4'd8;
  localparam logic [3:0] PH_EXTRA  = 4'd9;
  localparam logic [3:0] PH_CID    = 4'd10;
  localparam logic [3:0] PH_CSIZE  = 4'd11;
  localparam logic [3:0] PH_SKIP   = 4'd12;
  localparam logic [3:0] PH_DSIZE  = 4'd13;
  localparam logic [3:0] PH_STREAM = 4'd14;
  localparam logic [3:0] PH_HALT   = 4'd15;

  logic [3:0]  phase_q, phase_d, phase_c;
  logic [31:0] shift_q, shift_d, shift_c;
  logic [1:0]  wbi_q, wbi_d, wbi_c;
  logic [31:0] skip_q, skip_d, skip_c;
  logic [4:0]  extra_q, extra_d, extra_c;
  logic [1:0]  chan_q, chan_d, chan_c;
  logic [4:0]  bits_q, bits_d, bits_c;
  logic [31:0] rate_q, rate_d, rate_c;
  logic [31:0] remain_q, remain_d, remain_c;
  logic [2:0]  fbytes_q, fbytes_d, fbytes_c;
  logic [1:0]  fbi_q, fbi_d, fbi_c;

  logic [31:0] word;
  logic [31:0] frame;
  logic [15:0] hi_half;
  logic [4:0]  extra_dec;
  logic [31:0] skip_dec;

  always_comb begin
    if (item_i.file_start) begin
      phase_c  = PH_RIFF;
      shift_c  = '0;
      wbi_c    = '0;
      skip_c   = '0;
      extra_c  = '0;
      chan_c   = '0;
      bits_c   = '0;
      rate_c   = '0;
      remain_c = '0;
      fbytes_c = '0;
      fbi_c    = '0;
    end else begin
      phase_c  = phase_q;
      shift_c  = shift_q;
      wbi_c    = wbi_q;
      skip_c   = skip_q;
      extra_c  = extra_q;
      chan_c   = chan_q;
      bits_c   = bits_q;
      rate_c   = rate_q;
      remain_c = remain_q;
      fbytes_c = fbytes_q;
      fbi_c    = fbi_q;
    end
  end

  assign word      = {item_i.data_byte, shift_c[31:8]};
  assign hi_half   = word[31:16];
  assign extra_dec = (extra_c != '0) ? extra_c - 5'd1 : extra_c;
  assign skip_dec  = (skip_c != '0) ? skip_c - 32'd1 : skip_c;

  always_comb begin
    unique case (fbytes_c)
      3'd1:    frame = {24'd0, word[31:24]};
      3'd2:    frame = {16'd0, word[31:16]};
      default: frame = word;
    endcase
  end

  always_comb begin
    phase_d     = phase_c;
    shift_d     = shift_c;
    wbi_d       = wbi_c;
    skip_d      = skip_c;
    extra_d     = extra_c;
    chan_d      = chan_c;
    bits_d      = bits_c;
    rate_d      = rate_c;
    remain_d    = remain_c;
    fbytes_d    = fbytes_c;
    fbi_d       = fbi_c;
    res_valid_o = 1'b0;
    res_o       = '0;

    priority if (phase_c == PH_HALT) begin
      res_valid_o = 1'b0;
    end else if (phase_c == PH_STREAM) begin
      if (remain_c == '0) begin
        res_valid_o         = 1'b1;
        res_o.result_kind   = KIND_END;
        res_o.sample_rate   = rate_c;
        res_o.channel_count = chan_c;
        res_o.sample_bits   = bits_c;
        phase_d             = PH_HALT;
      end else begin
        remain_d = remain_c - 32'd1;
        shift_d  = word;
        if (({1'b0, fbi_c} + 3'd1) < fbytes_c) begin
          fbi_d = fbi_c + 2'd1;
        end else begin
          fbi_d               = '0;
          res_valid_o         = 1'b1;
          res_o.result_kind   = KIND_FRAME;
          res_o.sample_rate   = rate_c;
          res_o.channel_count = chan_c;
          res_o.sample_bits   = bits_c;
          if (bits_c == 5'd8) begin
            res_o.left_sample  = {8'd0, frame[7:0]};
            res_o.right_sample = (chan_c == 2'd2) ? {8'd0, frame[15:8]} : '0;
          end else begin
            res_o.left_sample  = frame[15:0];
            res_o.right_sample = (chan_c == 2'd2) ? frame[31:16] : '0;
          end
        end
      end
    end else if (phase_c == PH_EXTRA) begin
      extra_d = extra_dec;
      if (extra_dec == '0) begin
        phase_d = PH_CID;
      end
    end else if (phase_c == PH_SKIP) begin
      skip_d = skip_dec;
      if (skip_dec == '0) begin
        phase_d = PH_CID;
      end
    end else begin
      shift_d = word;
      if (wbi_c != 2'd3) begin
        wbi_d = wbi_c + 2'd1;
      end else begin
        wbi_d = '0;
        unique case (phase_c)
          PH_RIFF: begin
            if (word != TAG_RIFF) begin
              res_valid_o       = 1'b1;
              res_o.result_kind = KIND_ERROR;
              res_o.error_code  = ERR_RIFF;
              phase_d           = PH_HALT;
            end else begin
              phase_d = PH_RSIZE;
            end
          end
          PH_RSIZE: phase_d = PH_WAVE;
          PH_WAVE: begin
            if (word != TAG_WAVE) begin
              res_valid_o       = 1'b1;
              res_o.result_kind = KIND_ERROR;
              res_o.error_code  = ERR_WAVE;
              phase_d           = PH_HALT;
            end else begin
              phase_d = PH_HUNT;
            end
          end
          PH_HUNT: begin
            if (word == TAG_FMT) begin
              phase_d = PH_FSIZE;
            end
          end
          PH_FSIZE: begin
            phase_d = PH_TAGCH;
            priority if (word == FMT_SIZE_BASIC) begin
              extra_d = 5'd0;
            end else if (word == FMT_SIZE_EXT) begin
              extra_d = 5'd2;
            end else if (word == FMT_SIZE_WIDE) begin
              extra_d = 5'd24;
            end else begin
              res_valid_o       = 1'b1;
              res_o.result_kind = KIND_ERROR;
              res_o.error_code  = ERR_FSIZE;
              phase_d           = PH_HALT;
            end
          end
          PH_TAGCH: begin
            priority if (word[15:0] != 16'd1) begin
              res_valid_o       = 1'b1;
              res_o.result_kind = KIND_ERROR;
              res_o.error_code  = ERR_PCM;
              phase_d           = PH_HALT;
            end else if (hi_half != 16'd1 && hi_half != 16'd2) begin
              res_valid_o       = 1'b1;
              res_o.result_kind = KIND_ERROR;
              res_o.error_code  = ERR_CHAN;
              phase_d           = PH_HALT;
            end else begin
              chan_d  = hi_half[1:0];
              phase_d = PH_RATE;
            end
          end
          PH_RATE: begin
            if (word == '0) begin
              res_valid_o       = 1'b1;
              res_o.result_kind = KIND_ERROR;
              res_o.error_code  = ERR_RATE;
              phase_d           = PH_HALT;
            end else begin
              rate_d  = word;
              phase_d = PH_BRATE;
            end
          end
          PH_BRATE: phase_d = PH_ALBITS;
          PH_ALBITS: begin
            if (hi_half != 16'd8 && hi_half != 16'd16) begin
              res_valid_o       = 1'b1;
              res_o.result_kind = KIND_ERROR;
              res_o.error_code  = ERR_BITS;
              phase_d           = PH_HALT;
            end else begin
              bits_d   = hi_half[4:0];
              fbytes_d = {1'b0, chan_c} << ((hi_half == 16'd16) ? 1 : 0);
              phase_d  = (extra_c != '0) ? PH_EXTRA : PH_CID;
            end
          end
          PH_CID:   phase_d = (word == TAG_DATA) ? PH_DSIZE : PH_CSIZE;
          PH_CSIZE: begin
            skip_d  = word;
            phase_d = (word != '0) ? PH_SKIP : PH_CID;
          end
          PH_DSIZE: begin
            remain_d            = word;
            fbi_d               = '0;
            phase_d             = PH_STREAM;
            res_valid_o         = 1'b1;
            res_o.result_kind   = KIND_HEADER;
            res_o.sample_rate   = rate_c;
            res_o.channel_count = chan_c;
            res_o.sample_bits   = bits_c;
            res_o.data_length   = word;
          end
          default: phase_d = PH_HALT;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_RIFF;
      shift_q  <= '0;
      wbi_q    <= '0;
      skip_q   <= '0;
      extra_q  <= '0;
      chan_q   <= '0;
      bits_q   <= '0;
      rate_q   <= '0;
      remain_q <= '0;
      fbytes_q <= '0;
      fbi_q    <= '0;
    end else if (item_en_i) begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      wbi_q    <= wbi_d;
      skip_q   <= skip_d;
      extra_q  <= extra_d;
      chan_q   <= chan_d;
      bits_q   <= bits_d;
      rate_q   <= rate_d;
      remain_q <= remain_d;
      fbytes_q <= fbytes_d;
      fbi_q    <= fbi_d;
    end
  end

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_en_i && phase_q == PH_HALT && !item_i.file_start |-> !res_valid_o)
    else $error("result produced after halt");

  a_frame_in_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.result_kind == KIND_FRAME |-> phase_c == PH_STREAM)
    else $error("sample frame outside data chunk");

  a_frame_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_STREAM |-> fbytes_q == 3'd1 || fbytes_q == 3'd2 || fbytes_q == 3'd4)
    else $error("bad frame size in data chunk");

  a_stream_format: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_STREAM |-> (chan_q == 2'd1 || chan_q == 2'd2) &&
                             (bits_q == 5'd8 || bits_q == 5'd16))
    else $error("data chunk entered without valid format");

endmodule

// ===== hdl/wpsd_out_stage.sv =====
// ----------------------------------------------------------------------------
// wpsd_out_stage
// Result register facing the output stream.
// ----------------------------------------------------------------------------
module wpsd_out_stage
  import wpsd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    advance_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic    valid_q;
  result_t res_q;

  assign advance_o   = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== hdl/wav_pcm_stream_deparser_top.sv =====
// ----------------------------------------------------------------------------
// wav_pcm_stream_deparser_top
// Each accepted byte enters the input register, and the parser step then
// loads its result, if any, into the result register, which offers it.
// Throughput: one byte per cycle while the output side takes results.
// Reset: rst_ni clears both stages and puts the parser in front of the RIFF tag.
// Parses a RIFF/WAVE PCM byte stream into header, frame, error and end results.
// ----------------------------------------------------------------------------
module wav_pcm_stream_deparser_top
  import wpsd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,  // data_byte[7:0]
  input  logic               s_axis_tuser_i,  // file_start
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // left_sample[15:0], right_sample[31:16], sample_rate[63:32],
  // channel_count[65:64], sample_bits[70:66], data_length[102:71],
  // error_code[105:103], zero[111:106]
  output logic [TDATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]         m_axis_tuser_o   // result_kind
);

  in_item_t req_item;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign req_item.file_start = s_axis_tuser_i;
  assign req_item.data_byte  = s_axis_tdata_i;

  wpsd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid_i),
    .req_ready_o  (s_axis_tready_o),
    .req_item_i   (req_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  wpsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_en_i   (item_valid && advance),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wpsd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid && item_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (out_res)
  );

  assign m_axis_tuser_o = out_res.result_kind;
  assign m_axis_tdata_o = {6'd0,
                           out_res.error_code,
                           out_res.data_length,
                           out_res.sample_bits,
                           out_res.channel_count,
                           out_res.sample_rate,
                           out_res.right_sample,
                           out_res.left_sample};

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench of wav_pcm_stream_deparser_top. Sends WAV files one byte per
// request and checks every result field against a byte-level prediction of
// the parser. Covers every error code, all three format chunk sizes, hunted
// words, skipped chunks, partial frames, end of data, and restarts in the
// middle of a file, mostly as well-formed files with random content. Both
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wpsd_pkg::*;

  localparam int          QUIET_LIMIT   = 4000;
  localparam int          HOLD_CYCLES   = 200;
  localparam int          SETTLE_CYCLES = 8;
  localparam logic [15:0] FMT_TAG_PCM   = 16'd1;
  localparam logic [15:0] BITS_NARROW   = 16'd8;
  localparam logic [15:0] BITS_WIDE     = 16'd16;

  typedef enum logic [3:0] {
    SEEK_RIFF, SKIP_RSIZE, SEEK_WAVE, HUNT_FMT, READ_FSIZE, READ_TAGCH, READ_RATE,
    SKIP_BRATE, READ_BITS, SKIP_EXT, READ_CID, READ_CSIZE, SKIP_CHUNK, READ_DSIZE,
    STREAM, HALTED
  } wav_phase_e;

  typedef struct packed {
    logic [31:0] riff;
    logic [31:0] wave;
    logic [31:0] fsize;
    logic [15:0] fmt_tag;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    int          junk;
    int          chunks;
    logic        zero_chunk;
    logic        corners;
    logic [31:0] dlen;
    int          body;
  } wav_spec_t;

  class wav_stream_scoreboard;
    wav_phase_e  phase;
    logic [31:0] shreg;
    logic [31:0] skip_left;
    logic [31:0] data_left;
    logic [31:0] rate;
    logic [1:0]  chans;
    logic [4:0]  bits;
    int          word_pos;
    int          ext_left;
    int          frame_len;
    int          frame_pos;
    result_t     due[$];
    int          mismatches;
    int          checked;
    int          kind_seen[4];

    function new();
      restart();
      mismatches = 0;
      checked = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void restart();
      phase = SEEK_RIFF;
      shreg = '0;
      skip_left = '0;
      data_left = '0;
      rate = '0;
      chans = '0;
      bits = '0;
      word_pos = 0;
      ext_left = 0;
      frame_len = 0;
      frame_pos = 0;
    endfunction

    function result_t held(logic [1:0] kind);
      result_t r;
      r = '0;
      r.result_kind = kind;
      r.sample_rate = rate;
      r.channel_count = chans;
      r.sample_bits = bits;
      return r;
    endfunction

    function result_t abort(logic [2:0] code);
      result_t r;
      r = '0;
      r.result_kind = KIND_ERROR;
      r.error_code = code;
      phase = HALTED;
      return r;
    endfunction

    function bit take_word(output result_t r);
      r = '0;
      case (phase)
        SEEK_RIFF: begin
          if (shreg != TAG_RIFF) begin
            r = abort(ERR_RIFF);
            return 1'b1;
          end
          phase = SKIP_RSIZE;
        end
        SKIP_RSIZE: phase = SEEK_WAVE;
        SEEK_WAVE: begin
          if (shreg != TAG_WAVE) begin
            r = abort(ERR_WAVE);
            return 1'b1;
          end
          phase = HUNT_FMT;
        end
        HUNT_FMT: if (shreg == TAG_FMT) phase = READ_FSIZE;
        READ_FSIZE: begin
          if (shreg == FMT_SIZE_BASIC) ext_left = 0;
          else if (shreg == FMT_SIZE_EXT) ext_left = 2;
          else if (shreg == FMT_SIZE_WIDE) ext_left = 24;
          else begin
            r = abort(ERR_FSIZE);
            return 1'b1;
          end
          phase = READ_TAGCH;
        end
        READ_TAGCH: begin
          if (shreg[15:0] != FMT_TAG_PCM) begin
            r = abort(ERR_PCM);
            return 1'b1;
          end
          if (shreg[31:16] == 16'd0 || shreg[31:16] > 16'd2) begin
            r = abort(ERR_CHAN);
            return 1'b1;
          end
          chans = shreg[17:16];
          phase = READ_RATE;
        end
        READ_RATE: begin
          if (shreg == 32'd0) begin
            r = abort(ERR_RATE);
            return 1'b1;
          end
          rate = shreg;
          phase = SKIP_BRATE;
        end
        SKIP_BRATE: phase = READ_BITS;
        READ_BITS: begin
          if (shreg[31:16] != BITS_NARROW && shreg[31:16] != BITS_WIDE) begin
            r = abort(ERR_BITS);
            return 1'b1;
          end
          bits = shreg[20:16];
          frame_len = int'(chans) * (int'(bits) / 8);
          phase = (ext_left != 0) ? SKIP_EXT : READ_CID;
        end
        READ_CID: phase = (shreg == TAG_DATA) ? READ_DSIZE : READ_CSIZE;
        READ_CSIZE: begin
          skip_left = shreg;
          phase = (shreg != 32'd0) ? SKIP_CHUNK : READ_CID;
        end
        READ_DSIZE: begin
          data_left = shreg;
          frame_pos = 0;
          phase = STREAM;
          r = held(KIND_HEADER);
          r.data_length = shreg;
          return 1'b1;
        end
        default: phase = HALTED;
      endcase
      return 1'b0;
    endfunction

    function void note_byte(logic first, logic [7:0] b);
      result_t     r;
      bit          hit;
      logic [31:0] v;
      if (first) restart();
      hit = 1'b0;
      r = '0;
      case (phase)
        HALTED: ;
        STREAM: begin
          if (data_left == 32'd0) begin
            r = held(KIND_END);
            phase = HALTED;
            hit = 1'b1;
          end else begin
            data_left = data_left - 32'd1;
            shreg = {b, shreg[31:8]};
            if (frame_pos + 1 < frame_len) begin
              frame_pos++;
            end else begin
              frame_pos = 0;
              v = shreg >> ((32 - 8 * frame_len) % 32);
              r = held(KIND_FRAME);
              if (bits == 5'd8) begin
                r.left_sample = {8'h00, v[7:0]};
                if (chans == 2'd2) r.right_sample = {8'h00, v[15:8]};
              end else begin
                r.left_sample = v[15:0];
                if (chans == 2'd2) r.right_sample = v[31:16];
              end
              hit = 1'b1;
            end
          end
        end
        SKIP_EXT: begin
          if (ext_left > 0) ext_left--;
          if (ext_left == 0) phase = READ_CID;
        end
        SKIP_CHUNK: begin
          if (skip_left != 32'd0) skip_left = skip_left - 32'd1;
          if (skip_left == 32'd0) phase = READ_CID;
        end
        default: begin
          shreg = {b, shreg[31:8]};
          if (word_pos < 3) begin
            word_pos++;
          end else begin
            word_pos = 0;
            hit = take_word(r);
          end
        end
      endcase
      if (hit) due.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH: %s", msg);
    endtask

    task compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                  checked, name, got, want));
    endtask

    task check_result(logic [1:0] kind, logic [TDATA_W-1:0] d);
      result_t e;
      checked++;
      if (due.size() == 0) begin
        report_mismatch($sformatf("result %0d of kind %0d with nothing expected",
                                  checked, kind));
        return;
      end
      e = due.pop_front();
      kind_seen[e.result_kind]++;
      compare("kind", kind, e.result_kind);
      compare("left_sample", d[15:0], $unsigned(e.left_sample));
      compare("right_sample", d[31:16], $unsigned(e.right_sample));
      compare("sample_rate", d[63:32], e.sample_rate);
      compare("channel_count", d[65:64], e.channel_count);
      compare("sample_bits", d[70:66], e.sample_bits);
      compare("data_length", d[102:71], e.data_length);
      compare("error_code", d[105:103], e.error_code);
      compare("pad bits", d[111:106], '0);
    endtask

    task close_out();
      if (due.size() != 0)
        report_mismatch($sformatf("%0d expected results never arrived", due.size()));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [7:0]         s_axis_tdata_i = '0;
  logic               s_axis_tuser_i = 1'b0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata_o;
  logic [1:0]         m_axis_tuser_o;

  wav_stream_scoreboard book = new();
  logic [7:0]           file_bytes[$];
  int                   send_idle_pct = 0;
  int                   stall_pct = 0;
  int                   hold_asked = 0;
  int                   hold_seen = 0;
  int                   hold_left = 0;
  int                   quiet_cycles = 0;
  int                   bytes_sent = 0;
  int                   files_sent = 0;
  int                   bursts_sent = 0;

  wav_pcm_stream_deparser_top DUT (.*);

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) book.note_byte(s_axis_tuser_i, s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i) book.check_result(m_axis_tuser_o, m_axis_tdata_o);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic first, input logic [7:0] value);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= value;
    s_axis_tuser_i <= first;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
  endtask

  task automatic go_quiet();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic settle();
    while (book.due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [7:0] corner_byte(int i);
    case (i % 4)
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  function automatic logic [31:0] other_than(logic [31:0] w, logic [31:0] tag);
    return (w == tag) ? ~w : w;
  endfunction

  function automatic void put_word(logic [31:0] w);
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[23:16]);
    file_bytes.push_back(w[31:24]);
  endfunction

  function automatic void put_bytes(int n, logic corners);
    for (int i = 0; i < n; i++) file_bytes.push_back(corners ? corner_byte(i) : 8'($urandom));
  endfunction

  function automatic void compose(wav_spec_t s);
    int len;
    file_bytes.delete();
    put_word(s.riff);
    put_word($urandom);
    put_word(s.wave);
    repeat (s.junk) put_word(other_than($urandom, TAG_FMT));
    put_word(TAG_FMT);
    put_word(s.fsize);
    put_word({s.chans, s.fmt_tag});
    put_word(s.rate);
    put_word($urandom);
    put_word({s.bits, 16'($urandom)});
    if (s.fsize == FMT_SIZE_EXT) put_bytes(2, 1'b0);
    else if (s.fsize == FMT_SIZE_WIDE) put_bytes(24, 1'b0);
    for (int c = 0; c < s.chunks; c++) begin
      len = (c == 0 && s.zero_chunk) ? 0 : int'($urandom_range(1, 9));
      put_word(other_than($urandom, TAG_DATA));
      put_word(len);
      put_bytes(len, 1'b0);
    end
    put_word(TAG_DATA);
    put_word(s.dlen);
    put_bytes(s.body, s.corners);
  endfunction

  task automatic send_file();
    foreach (file_bytes[i]) push_byte(i == 0, file_bytes[i]);
    files_sent++;
  endtask

  task automatic send_spec(wav_spec_t s);
    compose(s);
    send_file();
  endtask

  task automatic send_cut(wav_spec_t s, int keep);
    compose(s);
    while (file_bytes.size() > keep) void'(file_bytes.pop_back());
    send_file();
  endtask

  function automatic wav_spec_t base_spec();
    wav_spec_t s;
    s.riff = TAG_RIFF;
    s.wave = TAG_WAVE;
    s.fsize = FMT_SIZE_BASIC;
    s.fmt_tag = FMT_TAG_PCM;
    s.chans = 16'd1;
    s.rate = 32'd44100;
    s.bits = BITS_NARROW;
    s.junk = 0;
    s.chunks = 0;
    s.zero_chunk = 1'b0;
    s.corners = 1'b1;
    s.dlen = 32'd4;
    s.body = 5;
    return s;
  endfunction

  function automatic wav_spec_t random_spec();
    wav_spec_t s;
    s = base_spec();
    case ($urandom_range(2))
      0:       s.fsize = FMT_SIZE_BASIC;
      1:       s.fsize = FMT_SIZE_EXT;
      default: s.fsize = FMT_SIZE_WIDE;
    endcase
    s.chans = 16'($urandom_range(1, 2));
    case ($urandom_range(9))
      0:       s.rate = 32'd1;
      1:       s.rate = 32'hFFFF_FFFF;
      default: s.rate = $urandom_range(8000, 192000);
    endcase
    s.bits = $urandom_range(1) ? BITS_NARROW : BITS_WIDE;
    s.junk = $urandom_range(0, 2);
    s.chunks = $urandom_range(0, 2);
    s.zero_chunk = ($urandom_range(3) == 0);
    s.corners = 1'b0;
    s.body = $urandom_range(0, 32);
    case ($urandom_range(3))
      0:       s.dlen = s.body - $urandom_range(0, (s.body < 3) ? s.body : 3);
      1:       s.dlen = s.body + $urandom_range(1, 8);
      default: s.dlen = s.body;
    endcase
    return s;
  endfunction

  function automatic wav_spec_t break_spec(wav_spec_t s);
    s.body = 0;
    s.chunks = 0;
    case ($urandom_range(6))
      0:       s.riff = s.riff ^ (32'd1 << $urandom_range(31));
      1:       s.wave = s.wave ^ (32'd1 << $urandom_range(31));
      2:       s.fsize = $urandom_range(0, 48);
      3:       s.fmt_tag = 16'($urandom_range(0, 3));
      4:       s.chans = $urandom_range(1) ? 16'd0 : 16'($urandom_range(3, 65535));
      5:       s.rate = 32'd0;
      default: s.bits = 16'($urandom_range(0, 32));
    endcase
    return s;
  endfunction

  task automatic directed_files();
    wav_spec_t s;
    s = base_spec(); s.riff = TAG_RIFF ^ 32'h0000_0100; s.body = 0; send_cut(s, 8);
    s = base_spec(); s.wave = TAG_RIFF; s.body = 0; send_cut(s, 16);
    s = base_spec(); s.fsize = 32'd17; s.body = 0; send_cut(s, 24);
    s = base_spec(); s.fsize = 32'hFFFF_FFFF; s.body = 0; send_cut(s, 24);
    s = base_spec(); s.fmt_tag = 16'h0000; s.chans = 16'd0; s.body = 0; send_cut(s, 28);
    s = base_spec(); s.fmt_tag = 16'hFFFF; s.body = 0; send_cut(s, 28);
    s = base_spec(); s.chans = 16'd0; s.body = 0; send_cut(s, 28);
    s = base_spec(); s.chans = 16'hFFFF; s.body = 0; send_cut(s, 28);
    s = base_spec(); s.rate = 32'd0; s.body = 0; send_cut(s, 32);
    s = base_spec(); s.bits = 16'd24; s.body = 0; send_cut(s, 40);
    s = base_spec(); send_spec(s);
    s = base_spec(); s.chans = 16'd2; s.bits = BITS_WIDE; s.fsize = FMT_SIZE_WIDE;
    s.rate = 32'hFFFF_FFFF; s.junk = 2; s.chunks = 2; s.zero_chunk = 1'b1;
    s.dlen = 32'd8; s.body = 10; send_spec(s);
    s = base_spec(); s.chans = 16'd2; s.fsize = FMT_SIZE_EXT; s.rate = 32'd1;
    s.dlen = 32'd5; s.body = 6; send_spec(s);
    s = base_spec(); s.bits = BITS_WIDE; s.dlen = 32'd0; s.body = 2; send_spec(s);
    s = base_spec(); s.chans = 16'd2; s.bits = BITS_WIDE; s.dlen = 32'hFFFF_FFFF;
    s.body = 12; send_spec(s);
  endtask

  task automatic random_request();
    wav_spec_t s;
    int        pick;
    int        n;
    int        keep;
    pick = $urandom_range(99);
    if (pick < 10) begin
      n = $urandom_range(4, 24);
      for (int i = 0; i < n; i++)
        push_byte(i == 0 ? 1'($urandom_range(1)) : ($urandom_range(15) == 0), 8'($urandom));
      bursts_sent++;
    end else begin
      s = random_spec();
      if (pick < 40) s = break_spec(s);
      compose(s);
      if (pick >= 90) begin
        keep = $urandom_range(1, file_bytes.size());
        while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      end
      send_file();
    end
  endtask

  initial begin
    wav_spec_t s;
    int        stop_at;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_files();
    go_quiet();
    settle();

    s = base_spec();
    s.chans = 16'd2;
    s.bits = BITS_WIDE;
    s.corners = 1'b0;
    s.dlen = 32'd48;
    s.body = 48;
    hold_asked++;
    send_spec(s);
    go_quiet();
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 72; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 72; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      stop_at = bytes_sent + 40;
      while (bytes_sent < stop_at) random_request();
      go_quiet();
      settle();
    end

    book.close_out();
    $display("Covered %0d bytes in %0d files and %0d noise bursts: %0d headers, %0d frames,",
             bytes_sent, files_sent, bursts_sent, book.kind_seen[KIND_HEADER],
             book.kind_seen[KIND_FRAME]);
    $display("%0d errors and %0d end markers, under idle, stall and hold-off phases",
             book.kind_seen[KIND_ERROR], book.kind_seen[KIND_END]);
    if (book.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== wav_pcm_stream_deparser_top.f =====
hdl/wpsd_pkg.sv
hdl/wpsd_in_stage.sv
hdl/wpsd_parser.sv
hdl/wpsd_out_stage.sv
hdl/wav_pcm_stream_deparser_top.sv
test/tb.sv
